@@ design/rhc_pkg.sv @@
// shared types and constants of the rgb to hsv converter
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 6;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned PCT_W = 13;

  localparam logic [HUE_W-1:0] HUE_MAX = 15'h7FFF;
  localparam logic [PCT_W-1:0] PCT_MAX = 13'h1FFF;

  // divisor of the value lane
  localparam logic [CH_W-1:0] VAL_DIV = 8'd255;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_e;

  typedef struct packed {
    rhc_sector_e     sector;
    logic            neg;
    logic            grey;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] maxv;
  } rhc_side_t;

endpackage

@@ design/rhc_pix_if.sv @@
// pixel input channel
`timescale 1ns / 1ps

interface rhc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::CH_W-1:0] red;
  logic [rhc_pkg::CH_W-1:0] green;
  logic [rhc_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/rhc_hsv_if.sv @@
// hsv result channel
`timescale 1ns / 1ps

interface rhc_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::HUE_W-1:0] hue;
  logic [rhc_pkg::PCT_W-1:0] saturation;
  logic [rhc_pkg::PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

@@ design/rhc_front.sv @@
// input stage: max, min, hue sector and divider operands
`timescale 1ns / 1ps

module rhc_front #(
  parameter int unsigned FRAC_BITS = rhc_pkg::FRAC_BITS_DEF,
  parameter int unsigned QW        = 13,
  parameter int unsigned W         = QW + 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [rhc_pkg::CH_W-1:0] red_i,
  input  logic [rhc_pkg::CH_W-1:0] green_i,
  input  logic [rhc_pkg::CH_W-1:0] blue_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output rhc_pkg::rhc_side_t        side_o,
  output logic [W-1:0]              hue_w_o,
  output logic [W-1:0]              sat_w_o,
  output logic [W-1:0]              val_w_o
);

  localparam int unsigned HUE_K = 60 << FRAC_BITS;
  localparam int unsigned PCT_K = 100 << FRAC_BITS;

  logic                      valid_q, valid_d, load;
  rhc_pkg::rhc_side_t        side_q, side_d;
  logic [W-1:0]              hue_w_q, hue_w_d, sat_w_q, sat_w_d, val_w_q, val_w_d;
  logic [rhc_pkg::CH_W-1:0] mx, mn;
  logic signed [rhc_pkg::CH_W:0] diff;
  logic [rhc_pkg::CH_W-1:0] num_abs;
  rhc_pkg::rhc_sector_e      sector;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    if (red_i >= green_i && red_i >= blue_i) begin
      sector = rhc_pkg::SEC_RED;
      diff   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sector = rhc_pkg::SEC_GREEN;
      diff   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector = rhc_pkg::SEC_BLUE;
      diff   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    num_abs = diff[rhc_pkg::CH_W] ? rhc_pkg::CH_W'(-diff) : diff[rhc_pkg::CH_W-1:0];

    side_d.sector = sector;
    side_d.neg    = diff[rhc_pkg::CH_W];
    side_d.delta  = mx - mn;
    side_d.grey   = (mx == mn);
    side_d.maxv   = mx;

    hue_w_d = W'(HUE_K) * {{(W-rhc_pkg::CH_W){1'b0}}, num_abs};
    sat_w_d = W'(PCT_K) * {{(W-rhc_pkg::CH_W){1'b0}}, side_d.delta};
    val_w_d = W'(PCT_K) * {{(W-rhc_pkg::CH_W){1'b0}}, mx};
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      side_q  <= side_d;
      hue_w_q <= hue_w_d;
      sat_w_q <= sat_w_d;
      val_w_q <= val_w_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign hue_w_o = hue_w_q;
  assign sat_w_o = sat_w_q;
  assign val_w_o = val_w_q;

endmodule

@@ design/rhc_div_cell.sv @@
// one restoring division step for the hue, saturation and value lanes
`timescale 1ns / 1ps

module rhc_div_cell #(
  parameter int unsigned QW = 13,
  parameter int unsigned W  = QW + 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rhc_pkg::rhc_side_t side_i,
  input  logic [W-1:0]       hue_w_i,
  input  logic [W-1:0]       sat_w_i,
  input  logic [W-1:0]       val_w_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rhc_pkg::rhc_side_t side_o,
  output logic [W-1:0]       hue_w_o,
  output logic [W-1:0]       sat_w_o,
  output logic [W-1:0]       val_w_o
);

  // remainder in the top bits, dividend bits shift out as quotient bits shift in
  function automatic logic [W-1:0] div_step(input logic [W-1:0] w,
                                            input logic [rhc_pkg::CH_W-1:0] d);
    logic [W-1:0] t;
    logic [8:0]   top;
    t   = w << 1;
    top = t[W-1:QW];
    if (top >= {1'b0, d}) begin
      t[W-1:QW] = top - {1'b0, d};
      t[0]      = 1'b1;
    end
    return t;
  endfunction

  logic               valid_q, valid_d, load;
  rhc_pkg::rhc_side_t side_q;
  logic [W-1:0]       hue_w_q, sat_w_q, val_w_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      side_q  <= side_i;
      hue_w_q <= div_step(hue_w_i, side_i.delta);
      sat_w_q <= div_step(sat_w_i, side_i.maxv);
      val_w_q <= div_step(val_w_i, rhc_pkg::VAL_DIV);
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign hue_w_o = hue_w_q;
  assign sat_w_o = sat_w_q;
  assign val_w_o = val_w_q;

endmodule

@@ design/rhc_back.sv @@
// output stage: hue sector offset, wrap, grey case and field limits
`timescale 1ns / 1ps

module rhc_back #(
  parameter int unsigned FRAC_BITS = rhc_pkg::FRAC_BITS_DEF,
  parameter int unsigned QW        = 13,
  parameter int unsigned W         = QW + 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rhc_pkg::rhc_side_t         side_i,
  input  logic [W-1:0]               hue_w_i,
  input  logic [W-1:0]               sat_w_i,
  input  logic [W-1:0]               val_w_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [rhc_pkg::HUE_W-1:0] hue_o,
  output logic [rhc_pkg::PCT_W-1:0] saturation_o,
  output logic [rhc_pkg::PCT_W-1:0] brightness_o
);

  localparam int unsigned HW  = $clog2((360 << FRAC_BITS) + 1);
  localparam int unsigned HCW = (HW > rhc_pkg::HUE_W) ? HW : rhc_pkg::HUE_W;
  localparam int unsigned PCW = (QW > rhc_pkg::PCT_W) ? QW : rhc_pkg::PCT_W;
  localparam logic [HW-1:0] H120 = HW'(120 << FRAC_BITS);
  localparam logic [HW-1:0] H240 = HW'(240 << FRAC_BITS);
  localparam logic [HW-1:0] H360 = HW'(360 << FRAC_BITS);

  logic                       valid_q, valid_d, load;
  logic [rhc_pkg::HUE_W-1:0] hue_q, hue_d;
  logic [rhc_pkg::PCT_W-1:0] sat_q, sat_d, val_q, val_d;
  logic [HW-1:0]              c, hue_full;
  logic [HCW-1:0]             hue_ext;
  logic [PCW-1:0]             sat_ext, val_ext;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    // negative offsets round up, so the sum rounds down
    c = HW'(hue_w_i[QW-1:0])
      + HW'(side_i.neg && (hue_w_i[W-1:QW] != '0));
    unique case (side_i.sector)
      rhc_pkg::SEC_RED:   hue_full = side_i.neg ? H360 - c : c;
      rhc_pkg::SEC_GREEN: hue_full = side_i.neg ? H120 - c : H120 + c;
      rhc_pkg::SEC_BLUE:  hue_full = side_i.neg ? H240 - c : H240 + c;
      default:            hue_full = '0;
    endcase
    hue_ext = HCW'(hue_full);
    sat_ext = PCW'(sat_w_i[QW-1:0]);
    val_ext = PCW'(val_w_i[QW-1:0]);

    hue_d = (hue_ext > HCW'(rhc_pkg::HUE_MAX)) ? rhc_pkg::HUE_MAX
                                                : hue_ext[rhc_pkg::HUE_W-1:0];
    sat_d = (sat_ext > PCW'(rhc_pkg::PCT_MAX)) ? rhc_pkg::PCT_MAX
                                                : sat_ext[rhc_pkg::PCT_W-1:0];
    val_d = (val_ext > PCW'(rhc_pkg::PCT_MAX)) ? rhc_pkg::PCT_MAX
                                                : val_ext[rhc_pkg::PCT_W-1:0];
    if (side_i.grey) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

endmodule

@@ design/rgb_to_hsv_converter.sv @@
// rgb to hsv converter top level: input stage, divider cell row, output stage
//
//  channel  | dir | payload                        | transfer when
//  pix_i    | in  | red, green, blue (8 b each)    | pix_i.valid && pix_i.ready
//  hsv_o    | out | hue 15 b, saturation, brightness 13 b | hsv_o.valid && hsv_o.ready
//
// one pixel per cycle unless the output is held; the row has QW division cells, one
// quotient bit each, QW = bits of 100 * 2^FRAC_BITS; every stage has its own valid flag
// and takes a new pixel when it is empty or draining, so bubbles close up; a held result
// stalls the input once every stage is full
// reset clears all stage valid flags; payload registers are not reset
`timescale 1ns / 1ps

module rgb_to_hsv_converter #(
  parameter int unsigned FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  rhc_pix_if.sink     pix_i,
  rhc_hsv_if.source   hsv_o
);

  localparam int unsigned QW = $clog2((100 << FRAC_BITS) + 1);
  localparam int unsigned W  = QW + 9;

  logic               valid [QW+1];
  logic               ready [QW+1];
  rhc_pkg::rhc_side_t side  [QW+1];
  logic [W-1:0]       hue_w [QW+1];
  logic [W-1:0]       sat_w [QW+1];
  logic [W-1:0]       val_w [QW+1];

  rhc_front #(.FRAC_BITS(FRAC_BITS), .QW(QW), .W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .side_o  (side[0]),
    .hue_w_o (hue_w[0]),
    .sat_w_o (sat_w[0]),
    .val_w_o (val_w[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rhc_div_cell #(.QW(QW), .W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .side_i  (side[k]),
      .hue_w_i (hue_w[k]),
      .sat_w_i (sat_w[k]),
      .val_w_i (val_w[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .side_o  (side[k+1]),
      .hue_w_o (hue_w[k+1]),
      .sat_w_o (sat_w[k+1]),
      .val_w_o (val_w[k+1])
    );
  end

  rhc_back #(.FRAC_BITS(FRAC_BITS), .QW(QW), .W(W)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid[QW]),
    .ready_o      (ready[QW]),
    .side_i       (side[QW]),
    .hue_w_i      (hue_w[QW]),
    .sat_w_i      (sat_w[QW]),
    .val_w_i      (val_w[QW]),
    .valid_o      (hsv_o.valid),
    .ready_i      (hsv_o.ready),
    .hue_o        (hsv_o.hue),
    .saturation_o (hsv_o.saturation),
    .brightness_o (hsv_o.brightness)
  );

  // accepted pixel lands in the input stage
  a_front_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> valid[0])
    else $error("accepted pixel missing from input stage");

  // grey pixel leaves with zero hue and saturation
  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[QW] && ready[QW] && side[QW].grey |=>
      hsv_o.valid && hsv_o.hue == '0 && hsv_o.saturation == '0)
    else $error("grey pixel gave nonzero hue or saturation");

  // quotients from the cell row stay within full scale
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[QW] && !side[QW].grey |->
      sat_w[QW][QW-1:0] <= QW'(100 << FRAC_BITS)
      && val_w[QW][QW-1:0] <= QW'(100 << FRAC_BITS)
      && hue_w[QW][QW-1:0] <= QW'(60 << FRAC_BITS))
    else $error("division quotient out of range");

endmodule
